FILE: rtl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared widths, register indexes and constants for the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 16'd480;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int SUM_W   = 12;
    localparam int RECIP_W = 13;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
    localparam logic [SUM_W-1:0]   SUM_MAX = 12'd2295;
    localparam logic [PIX_W-1:0]   PIX_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pix;

endpackage

FILE: rtl/box_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_unit
// Streaming 3x3 mean filter with two line stores and a 3x3 window.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on i_valid / o_stall, one item per pixel.
// For every pixel at row two or later and column two or later, one item
// leaves on o_valid / i_stall carrying the floor of the mean of the 3x3
// neighbourhood that ends at that pixel, saturated at 255. The item caused
// by the last pixel of the frame has o_last_of_frame set.
// The datapath is a four-stage pipeline: line store read, window shift,
// window sum, and the divide by nine into the output register. One pixel
// can be accepted every cycle while o_stall is low, as each stage moves up
// whenever the one after it is empty or is being emptied.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; o_stall rises only once every stage is full.
// Reset empties the pipeline, sets width 640 and height 480 and restarts
// the frame. The line stores are not cleared and need no clearing pass.
// A write to either register restarts the frame at row zero, column zero;
// the user makes writes only while the block is empty; it is not enforced.
// ----------------------------------------------------------------------------
module box_filter_3x3_unit #(
    parameter int MAX_WIDTH = bf3_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bf3_pkg::PIX_W-1:0]       i_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bf3_pkg::PIX_W-1:0]       o_mean_pixel,
    output logic                            o_last_of_frame
);
    import bf3_pkg::*;

    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (CFG_WIDTH_W > MW) ? CFG_WIDTH_W : MW;

    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic [AW-1:0]           r_col;
    logic [CFG_HEIGHT_W-1:0] r_row;

    t_pix r_older_row [MAX_WIDTH];
    t_pix r_newer_row [MAX_WIDTH];

    logic          r_v1;
    t_pix          r_px1;
    t_pix          r_old_rd;
    t_pix          r_new_rd;
    logic [AW-1:0] r_col1;
    logic          r_emit1;
    logic          r_last1;

    logic          r_v2;
    logic          r_last2;
    t_pix          r_win [3][3];

    logic             r_v3;
    logic             r_last3;
    logic [SUM_W-1:0] r_sum;

    logic r_ov;
    t_pix r_mean;
    logic r_last;

    logic [EW-1:0]           w_ext;
    logic [EW-1:0]           w_eff;
    logic [AW-1:0]           col_last;
    logic [CFG_HEIGHT_W-1:0] h_eff;
    logic [CFG_HEIGHT_W-1:0] row_last;
    logic                    col_end;
    logic                    out_ready;
    logic                    s3_ready;
    logic                    s2_ready;
    logic                    s1_ready;
    logic                    in_acc;
    logic                    s1_adv;
    logic                    s2_adv;
    logic                    s3_adv;
    logic [SUM_W-1:0]        win_sum;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-RECIP_SHIFT-1:0] quot;
    t_pix                    n_mean;

    assign w_ext = EW'(r_width);
    always_comb begin
        if (w_ext < EW'(3)) begin
            w_eff = EW'(3);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
    end
    assign col_last = AW'(w_eff - EW'(1));
    assign h_eff    = (r_height < CFG_HEIGHT_W'(3)) ? CFG_HEIGHT_W'(3) : r_height;
    assign row_last = h_eff - CFG_HEIGHT_W'(1);
    assign col_end  = (r_col == col_last);

    assign out_ready = !r_ov || !i_stall;
    assign s3_ready  = !r_v3 || out_ready;
    assign s2_ready  = !r_v2 || s3_ready;
    assign s1_ready  = !r_v1 || s2_ready;
    assign o_stall   = !s1_ready;
    assign in_acc    = i_valid && s1_ready;
    assign s1_adv    = r_v1 && s2_ready;
    assign s2_adv    = r_v2 && s3_ready;
    assign s3_adv    = r_v3 && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[CFG_WIDTH_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= (r_row == row_last) ? '0 : r_row + CFG_HEIGHT_W'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old_rd <= r_older_row[r_col];
            r_new_rd <= r_newer_row[r_col];
        end
        if (s1_adv) begin
            r_older_row[r_col1] <= r_new_rd;
            r_newer_row[r_col1] <= r_px1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px1   <= i_pixel;
            r_col1  <= r_col;
            r_emit1 <= (r_row >= CFG_HEIGHT_W'(2)) && (r_col >= AW'(2));
            r_last1 <= (r_row == row_last) && col_end;
        end
        if (s1_adv) begin
            r_last2 <= r_last1;
        end
        if (s2_adv) begin
            r_sum   <= win_sum;
            r_last3 <= r_last2;
        end
        if (s3_adv) begin
            r_mean <= n_mean;
            r_last <= r_last3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= r_old_rd;
            r_win[1][2] <= r_new_rd;
            r_win[2][2] <= r_px1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= i_valid;
            end
            if (s2_ready) begin
                r_v2 <= r_v1 && r_emit1;
            end
            if (s3_ready) begin
                r_v3 <= r_v2;
            end
            if (out_ready) begin
                r_ov <= r_v3;
            end
        end
    end

    always_comb begin
        win_sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                win_sum = win_sum + SUM_W'(r_win[i][j]);
            end
        end
    end

    assign prod   = PROD_W'(r_sum) * PROD_W'(RECIP_9);
    assign quot   = prod[PROD_W-1:RECIP_SHIFT];
    assign n_mean = (quot > (PROD_W-RECIP_SHIFT)'(PIX_MAX)) ? PIX_MAX : quot[PIX_W-1:0];

    assign o_valid         = r_ov;
    assign o_mean_pixel    = r_mean;
    assign o_last_of_frame = r_last;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= col_last)
        else $error("column position beyond image width");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_sum <= SUM_MAX)
        else $error("window sum out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_ov && i_stall))
        else $error("input stalled with a free stage");

endmodule
